// ===== hdl/jten_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the JSON token-to-event nesting unit.
// No dependencies; imported by every module of the block.
package jten_pkg;

    typedef logic [3:0] t_kind;
    typedef logic [1:0] t_parent;

    // Token kinds on the input channel
    localparam t_kind TOK_ERROR    = 4'd0;
    localparam t_kind TOK_OBJOPEN  = 4'd1;
    localparam t_kind TOK_OBJCLOSE = 4'd2;
    localparam t_kind TOK_ARROPEN  = 4'd3;
    localparam t_kind TOK_ARRCLOSE = 4'd4;
    localparam t_kind TOK_COLON    = 4'd5;
    localparam t_kind TOK_COMMA    = 4'd6;
    localparam t_kind TOK_STRING   = 4'd7;
    localparam t_kind TOK_UNSIGNED = 4'd8;
    localparam t_kind TOK_INTEGER  = 4'd9;
    localparam t_kind TOK_FLOAT    = 4'd10;
    localparam t_kind TOK_BOOL     = 4'd11;
    localparam t_kind TOK_NULL     = 4'd12;
    localparam t_kind TOK_END      = 4'd13;

    // Event kinds on the output channel
    localparam t_kind EV_ERROR    = 4'd0;
    localparam t_kind EV_OBJOPEN  = 4'd1;
    localparam t_kind EV_OBJCLOSE = 4'd2;
    localparam t_kind EV_ARROPEN  = 4'd3;
    localparam t_kind EV_ARRCLOSE = 4'd4;
    localparam t_kind EV_NAME     = 4'd5;
    localparam t_kind EV_STRING   = 4'd6;
    localparam t_kind EV_UNSIGNED = 4'd7;
    localparam t_kind EV_INTEGER  = 4'd8;
    localparam t_kind EV_FLOAT    = 4'd9;
    localparam t_kind EV_BOOL     = 4'd10;
    localparam t_kind EV_NULL     = 4'd11;
    localparam t_kind EV_END      = 4'd12;

    localparam t_parent PARENT_NONE   = 2'd0;
    localparam t_parent PARENT_OBJECT = 2'd1;
    localparam t_parent PARENT_ARRAY  = 2'd2;

    localparam logic LAYER_OBJECT = 1'b0;
    localparam logic LAYER_ARRAY  = 1'b1;

    // Command broadcast to every stack cell
    typedef struct packed {
        logic push;
        logic pop;
        logic layer;
    } t_stack_cmd;

endpackage

// ===== hdl/jten_cell.sv =====
`timescale 1ns / 1ps
// One stack cell: holds a single container layer bit and trades it with
// its neighbors on push and pop. Depends on jten_pkg.
module jten_cell
    import jten_pkg::*;
(
    input  logic       i_clk,
    input  t_stack_cmd i_cmd,
    input  logic       i_from_above,
    input  logic       i_from_below,
    output logic       o_layer
);

    logic r_layer;
    logic n_layer;

    always_comb begin
        n_layer = r_layer;
        if (i_cmd.push) begin
            n_layer = i_from_above;
        end else if (i_cmd.pop) begin
            n_layer = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_layer <= n_layer;
    end

    assign o_layer = r_layer;

endmodule

// ===== hdl/jten_stack.sv =====
`timescale 1ns / 1ps
// Container stack as a row of shifting cells with the top in cell 0,
// plus the fill count. Depends on jten_pkg and jten_cell.
module jten_stack
    import jten_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stack_cmd       i_cmd,
    output logic [CNT_W-1:0] o_count,
    output logic             o_top,
    output logic             o_second
);

    logic [STACK_DEPTH-1:0] w_layer;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic w_above;
            logic w_below;
            if (g == 0) begin : g_first
                assign w_above = i_cmd.layer;
            end else begin : g_mid
                assign w_above = w_layer[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign w_below = 1'b0;
            end else begin : g_inner
                assign w_below = w_layer[g+1];
            end
            jten_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (i_cmd),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_layer      (w_layer[g])
            );
        end
        if (STACK_DEPTH > 1) begin : g_second
            assign o_second = w_layer[1];
        end else begin : g_no_second
            assign o_second = 1'b0;
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_top   = w_layer[0];

endmodule

// ===== hdl/json_token_to_event_nesting_unit.sv =====
`timescale 1ns / 1ps
// JSON token to pull-parser event unit. An event appears in the output
// register in the cycle after its token is accepted. Throughput: one
// token per cycle unless stalled; stack cells shift in the same cycle.
// Input stalls only while a held event is stalled downstream.
// Synchronous reset clears the stack count, key, flags and output valid;
// stack cell contents are not cleared. Depends on jten_pkg, jten_stack.
module json_token_to_event_nesting_unit
    import jten_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_kind,
    input  logic [3:0]  i_next_kind,
    input  logic [15:0] i_token_ref,
    input  logic [63:0] i_token_value,
    input  logic [3:0]  i_error_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_kind,
    output logic [1:0]  o_parent_kind,
    output logic        o_name_present,
    output logic [15:0] o_name_ref,
    output logic [15:0] o_event_ref,
    output logic [63:0] o_event_value,
    output logic [3:0]  o_event_error
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    logic             w_accept;
    t_stack_cmd       w_cmd;
    logic [CNT_W-1:0] w_count;
    logic             w_top;
    logic             w_second;
    t_parent          w_parent;
    t_parent          w_parent_pop;

    logic        r_key_valid, n_key_valid;
    logic [15:0] r_key_ref, n_key_ref;
    logic        r_after_colon, n_after_colon;

    logic        r_out_valid;
    logic [3:0]  r_event_kind;
    logic [1:0]  r_parent_kind;
    logic        r_name_present;
    logic [15:0] r_name_ref;
    logic [15:0] r_event_ref;
    logic [63:0] r_event_value;
    logic [3:0]  r_event_error;

    logic        n_emit;
    logic        n_use_name;
    logic [3:0]  n_event_kind;
    t_parent     n_parent_kind;
    logic [15:0] n_event_ref;
    logic [63:0] n_event_value;
    logic [3:0]  n_event_error;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    jten_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_count  (w_count),
        .o_top    (w_top),
        .o_second (w_second)
    );

    always_comb begin
        if (w_count == '0) begin
            w_parent = PARENT_NONE;
        end else begin
            w_parent = w_top ? PARENT_ARRAY : PARENT_OBJECT;
        end
        // parent after a pop: the entry below the top, or none
        if (w_count <= CNT_W'(1)) begin
            w_parent_pop = PARENT_NONE;
        end else begin
            w_parent_pop = w_second ? PARENT_ARRAY : PARENT_OBJECT;
        end
    end

    always_comb begin
        w_cmd         = '0;
        n_emit        = 1'b0;
        n_use_name    = 1'b1;
        n_event_kind  = EV_ERROR;
        n_parent_kind = w_parent;
        n_event_ref   = '0;
        n_event_value = '0;
        n_event_error = '0;
        n_key_valid   = r_key_valid;
        n_key_ref     = r_key_ref;
        n_after_colon = r_after_colon;

        case (i_kind)
            TOK_ERROR: begin
                n_emit        = 1'b1;
                n_event_kind  = EV_ERROR;
                n_event_ref   = i_token_ref;
                n_event_error = i_error_code;
            end
            TOK_OBJOPEN, TOK_ARROPEN: begin
                n_emit        = 1'b1;
                n_use_name    = 1'b0;
                n_event_kind  = i_kind;
                n_event_ref   = i_token_ref;
                w_cmd.push    = w_accept && (w_count != CNT_FULL);
                w_cmd.layer   = (i_kind == TOK_ARROPEN) ? LAYER_ARRAY : LAYER_OBJECT;
                n_key_valid   = 1'b0;
                n_key_ref     = '0;
                n_after_colon = 1'b0;
            end
            TOK_OBJCLOSE, TOK_ARRCLOSE: begin
                n_emit        = 1'b1;
                n_use_name    = 1'b0;
                n_event_kind  = i_kind;
                n_event_ref   = i_token_ref;
                n_parent_kind = w_parent_pop;
                w_cmd.pop     = w_accept && (w_count != '0);
                n_key_valid   = 1'b0;
                n_key_ref     = '0;
                n_after_colon = 1'b0;
            end
            TOK_COLON: begin
                n_emit        = (w_parent == PARENT_OBJECT) &&
                                ((i_next_kind == TOK_OBJOPEN) ||
                                 (i_next_kind == TOK_ARROPEN));
                n_event_kind  = EV_NAME;
                n_after_colon = 1'b1;
            end
            TOK_COMMA: begin
                n_key_valid   = 1'b0;
                n_key_ref     = '0;
                n_after_colon = 1'b0;
            end
            TOK_STRING: begin
                if ((w_parent != PARENT_OBJECT) || r_after_colon) begin
                    n_emit       = 1'b1;
                    n_event_kind = EV_STRING;
                    n_event_ref  = i_token_ref;
                end else begin
                    // store the key instead of emitting it
                    n_key_ref   = i_token_ref;
                    n_key_valid = 1'b1;
                end
                n_after_colon = 1'b0;
            end
            TOK_UNSIGNED, TOK_INTEGER, TOK_FLOAT, TOK_BOOL: begin
                n_emit        = 1'b1;
                n_event_kind  = i_kind - 4'd1;
                n_event_ref   = i_token_ref;
                n_event_value = i_token_value;
                n_after_colon = 1'b0;
            end
            TOK_NULL: begin
                n_emit        = 1'b1;
                n_event_kind  = EV_NULL;
                n_event_ref   = i_token_ref;
                n_after_colon = 1'b0;
            end
            TOK_END: begin
                n_emit       = 1'b1;
                n_event_kind = EV_END;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_valid   <= 1'b0;
            r_key_ref     <= '0;
            r_after_colon <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_key_valid   <= n_key_valid;
                r_key_ref     <= n_key_ref;
                r_after_colon <= n_after_colon;
            end
            if (w_accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load only with a new event, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_event_kind  <= n_event_kind;
            r_parent_kind <= n_parent_kind;
            if (n_use_name && (w_parent == PARENT_OBJECT) && r_key_valid) begin
                r_name_present <= 1'b1;
                r_name_ref     <= r_key_ref;
            end else begin
                r_name_present <= 1'b0;
                r_name_ref     <= '0;
            end
            r_event_ref   <= n_event_ref;
            r_event_value <= n_event_value;
            r_event_error <= n_event_error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_event_kind;
    assign o_parent_kind  = r_parent_kind;
    assign o_name_present = r_name_present;
    assign o_name_ref     = r_name_ref;
    assign o_event_ref    = r_event_ref;
    assign o_event_value  = r_event_value;
    assign o_event_error  = r_event_error;

endmodule

// ===== hdl/jten_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for json_token_to_event_nesting_unit, bound to it.
// Depends on jten_pkg and the top level's port list.
module jten_checker
    import jten_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_event_kind,
    input logic [1:0]  o_parent_kind,
    input logic        o_name_present,
    input logic [15:0] o_name_ref,
    input logic [15:0] o_event_ref
);

    // a held event stays until taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("event dropped while stalled");

    // input backpressure only ever comes from a stalled held event
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled event");

    a_name_in_object: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_name_present) |-> (o_parent_kind == PARENT_OBJECT))
        else $error("key attached outside an object");

    a_no_name_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_name_present) |-> (o_name_ref == 16'd0))
        else $error("key handle without a key");

    a_name_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind == EV_NAME)) |->
            ((o_parent_kind == PARENT_OBJECT) && (o_event_ref == 16'd0)))
        else $error("malformed name event");

endmodule

bind json_token_to_event_nesting_unit jten_checker u_jten_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_event_kind   (o_event_kind),
    .o_parent_kind  (o_parent_kind),
    .o_name_present (o_name_present),
    .o_name_ref     (o_name_ref),
    .o_event_ref    (o_event_ref)
);

// ===== bench/tb_json_token_to_event_nesting_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for json_token_to_event_nesting_unit: directed token runs,
// then random JSON documents and noise under changing idle patterns.
// Depends on jten_pkg and the RTL of the unit; predicts each event in-line.
module tb_json_token_to_event_nesting_unit;
    import jten_pkg::*;

    localparam int NEST_DEPTH   = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        t_kind       kind;
        t_parent     parent;
        logic        has_name;
        logic [15:0] name_ref;
        logic [15:0] text_ref;
        logic [63:0] value;
        logic [3:0]  err_code;
    } t_nest_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_kind = '0;
    logic [3:0]  i_next_kind = '0;
    logic [15:0] i_token_ref = '0;
    logic [63:0] i_token_value = '0;
    logic [3:0]  i_error_code = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_event_kind;
    logic [1:0]  o_parent_kind;
    logic        o_name_present;
    logic [15:0] o_name_ref;
    logic [15:0] o_event_ref;
    logic [63:0] o_event_value;
    logic [3:0]  o_event_error;

    // Shadow of the unit's nesting state
    logic        nest_layer [NEST_DEPTH];
    int          nest_count = 0;
    logic [15:0] held_key = '0;
    logic        key_held = 1'b0;
    logic        after_colon = 1'b0;

    t_nest_event pending_events [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          tokens_sent = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    json_token_to_event_nesting_unit #(
        .STACK_DEPTH(NEST_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_next_kind    (i_next_kind),
        .i_token_ref    (i_token_ref),
        .i_token_value  (i_token_value),
        .i_error_code   (i_error_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_parent_kind  (o_parent_kind),
        .o_name_present (o_name_present),
        .o_name_ref     (o_name_ref),
        .o_event_ref    (o_event_ref),
        .o_event_value  (o_event_value),
        .o_event_error  (o_event_error)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic t_parent nest_parent();
        if (nest_count == 0)
            return PARENT_NONE;
        return (nest_layer[nest_count - 1] == LAYER_ARRAY) ? PARENT_ARRAY : PARENT_OBJECT;
    endfunction

    function automatic void clear_key();
        held_key    = '0;
        key_held    = 1'b0;
        after_colon = 1'b0;
    endfunction

    // Advance the shadow state by one token and queue the event it causes
    function automatic void predict_event(input t_kind kind, input t_kind nxt,
                                          input logic [15:0] tok_ref,
                                          input logic [63:0] tok_value,
                                          input logic [3:0] err);
        t_nest_event ev;
        t_parent     parent;
        logic        fire;
        ev     = '0;
        parent = nest_parent();
        fire   = 1'b1;
        case (kind)
            TOK_ERROR: begin
                ev.kind     = EV_ERROR;
                ev.text_ref = tok_ref;
                ev.err_code = err;
            end
            TOK_OBJOPEN, TOK_ARROPEN: begin
                ev.kind     = (kind == TOK_OBJOPEN) ? EV_OBJOPEN : EV_ARROPEN;
                ev.text_ref = tok_ref;
                if (nest_count < NEST_DEPTH) begin
                    nest_layer[nest_count] = (kind == TOK_OBJOPEN) ? LAYER_OBJECT : LAYER_ARRAY;
                    nest_count++;
                end
                clear_key();
            end
            TOK_OBJCLOSE, TOK_ARRCLOSE: begin
                ev.kind     = (kind == TOK_OBJCLOSE) ? EV_OBJCLOSE : EV_ARRCLOSE;
                ev.text_ref = tok_ref;
                if (nest_count > 0)
                    nest_count--;
                parent = nest_parent();
                clear_key();
            end
            TOK_COLON: begin
                fire = (parent == PARENT_OBJECT) && (nxt == TOK_OBJOPEN || nxt == TOK_ARROPEN);
                ev.kind = EV_NAME;
                after_colon = 1'b1;
            end
            TOK_COMMA: begin
                fire = 1'b0;
                clear_key();
            end
            TOK_STRING: begin
                if (parent != PARENT_OBJECT || after_colon) begin
                    ev.kind     = EV_STRING;
                    ev.text_ref = tok_ref;
                end else begin
                    // key inside an object: hold it, emit nothing
                    fire     = 1'b0;
                    held_key = tok_ref;
                    key_held = 1'b1;
                end
                after_colon = 1'b0;
            end
            TOK_UNSIGNED, TOK_INTEGER, TOK_FLOAT, TOK_BOOL: begin
                ev.kind     = kind - (TOK_UNSIGNED - EV_UNSIGNED);
                ev.text_ref = tok_ref;
                ev.value    = tok_value;
                after_colon = 1'b0;
            end
            TOK_NULL: begin
                ev.kind     = EV_NULL;
                ev.text_ref = tok_ref;
                after_colon = 1'b0;
            end
            TOK_END: ev.kind = EV_END;
            default: fire = 1'b0;
        endcase
        if (fire) begin
            ev.parent = parent;
            if (parent == PARENT_OBJECT && key_held) begin
                ev.has_name = 1'b1;
                ev.name_ref = held_key;
            end
            pending_events.push_back(ev);
        end
    endfunction

    function automatic string event_text(input t_nest_event ev);
        return $sformatf("kind=%0d parent=%0d name=%0b/%h ref=%h value=%h err=%0d",
                         ev.kind, ev.parent, ev.has_name, ev.name_ref, ev.text_ref,
                         ev.value, ev.err_code);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin : check_events
        t_nest_event got;
        t_nest_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_event_kind, o_parent_kind, o_name_present, o_name_ref,
                    o_event_ref, o_event_value, o_event_error};
            if (pending_events.size() == 0) begin
                note_mismatch({"unexpected event: ", event_text(got)});
            end else begin
                want = pending_events.pop_front();
                if (got.kind !== want.kind || got.parent !== want.parent ||
                    got.has_name !== want.has_name || got.name_ref !== want.name_ref ||
                    got.text_ref !== want.text_ref || got.value !== want.value ||
                    got.err_code !== want.err_code)
                    note_mismatch({"expected ", event_text(want), " actual ", event_text(got)});
            end
        end
    end

    // Drive one item, hold it until accepted, then predict
    task automatic send_token(input t_kind kind, input t_kind nxt, input logic [15:0] tok_ref,
                              input logic [63:0] tok_value, input logic [3:0] err);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_next_kind   <= nxt;
        i_token_ref   <= tok_ref;
        i_token_value <= tok_value;
        i_error_code  <= err;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_event(kind, nxt, tok_ref, tok_value, err);
        if (kind <= TOK_END)
            tokens_sent++;
    endtask

    function automatic t_kind rand_kind();
        return t_kind'($urandom_range(0, 15));
    endfunction

    task automatic send_rand(input t_kind kind, input t_kind nxt);
        send_token(kind, nxt, 16'($urandom_range(0, 65535)), {$urandom, $urandom},
                   4'($urandom_range(0, 15)));
    endtask

    function automatic t_kind pick_value(input logic allow_open);
        if (allow_open && $urandom_range(0, 99) < 45)
            return $urandom_range(0, 1) ? TOK_ARROPEN : TOK_OBJOPEN;
        case ($urandom_range(0, 5))
            0: return TOK_STRING;
            1: return TOK_UNSIGNED;
            2: return TOK_INTEGER;
            3: return TOK_FLOAT;
            4: return TOK_BOOL;
            default: return TOK_NULL;
        endcase
    endfunction

    // One well-formed document with random content and a little noise
    task automatic send_document(input int goal_depth, input int budget);
        logic  open_arr [$];
        logic  open_first [$];
        t_kind vk;
        int    left;
        logic  closing;
        left = budget;
        vk   = $urandom_range(0, 1) ? TOK_ARROPEN : TOK_OBJOPEN;
        send_rand(vk, rand_kind());
        open_arr.push_back(vk == TOK_ARROPEN);
        open_first.push_back(1'b1);
        while (open_arr.size() != 0) begin
            left--;
            if ($urandom_range(0, 99) < 3)
                send_rand(rand_kind(), rand_kind());
            if (left <= 0 || open_arr.size() >= goal_depth)
                closing = ($urandom_range(0, 99) < 60);
            else
                closing = ($urandom_range(0, 99) < 12);
            if (closing) begin
                send_rand(open_arr[open_arr.size() - 1] ? TOK_ARRCLOSE : TOK_OBJCLOSE, rand_kind());
                void'(open_arr.pop_back());
                void'(open_first.pop_back());
            end else begin
                if (!open_first[open_first.size() - 1] && $urandom_range(0, 9) != 0)
                    send_rand(TOK_COMMA, rand_kind());
                open_first[open_first.size() - 1] = 1'b0;
                vk = pick_value(open_arr.size() < goal_depth && left > 0);
                if (!open_arr[open_arr.size() - 1]) begin
                    send_rand(TOK_STRING, rand_kind());
                    send_rand(TOK_COLON, vk);
                end
                send_rand(vk, rand_kind());
                if (vk == TOK_OBJOPEN || vk == TOK_ARROPEN) begin
                    open_arr.push_back(vk == TOK_ARROPEN);
                    open_first.push_back(1'b1);
                end
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_rand(TOK_END, rand_kind());
    endtask

    task automatic test_token_kinds();
        send_token(TOK_END, TOK_END, 16'hFFFF, '1, 4'hF);
        send_token(TOK_ERROR, TOK_OBJOPEN, 16'hFFFF, '1, 4'hF);
        send_token(TOK_ERROR, TOK_ERROR, 16'h0000, '0, 4'h0);
        send_token(TOK_OBJCLOSE, TOK_ARRCLOSE, 16'h1234, '0, 4'h0);
        send_token(TOK_ARRCLOSE, TOK_OBJCLOSE, 16'h4321, '0, 4'h0);
        send_token(t_kind'(14), t_kind'(14), 16'hFFFF, '1, 4'hF);
        send_token(t_kind'(15), t_kind'(15), 16'h0000, '0, 4'h0);
        send_token(TOK_UNSIGNED, TOK_NULL, 16'hFFFF, '1, 4'h5);
        send_token(TOK_STRING, TOK_COLON, 16'h0001, '0, 4'h0);
        send_token(TOK_NULL, TOK_END, 16'h8000, 64'h8000_0000_0000_0000, 4'h0);
    endtask

    task automatic test_key_naming();
        send_token(TOK_OBJOPEN, TOK_STRING, 16'h0010, '0, 4'h0);
        send_token(TOK_STRING, TOK_COLON, 16'hABCD, '0, 4'h0);
        send_token(TOK_COLON, TOK_ARROPEN, 16'h0011, '0, 4'h0);
        send_token(TOK_ARROPEN, TOK_INTEGER, 16'h0012, '0, 4'h0);
        send_token(TOK_INTEGER, TOK_COMMA, 16'h0013, '0, 4'h0);
        send_token(TOK_FLOAT, TOK_COMMA, 16'h0014, '1, 4'h0);
        send_token(TOK_BOOL, TOK_COMMA, 16'h0015, 64'h1, 4'h0);
        send_token(TOK_COMMA, TOK_STRING, 16'h0016, '0, 4'h0);
        send_token(TOK_STRING, TOK_ARRCLOSE, 16'h0017, '0, 4'h0);
        send_token(TOK_ARRCLOSE, TOK_COMMA, 16'h0018, '0, 4'h0);
        send_token(TOK_COMMA, TOK_STRING, 16'h0019, '0, 4'h0);
        send_token(TOK_STRING, TOK_COLON, 16'hFFFF, '0, 4'h0);
        send_token(TOK_COLON, TOK_STRING, 16'h001A, '0, 4'h0);
        send_token(TOK_STRING, TOK_END, 16'h001B, '0, 4'h0);
        send_token(TOK_END, TOK_COLON, 16'h001C, '0, 4'h0);
        // key still held: colon before an object names it
        send_token(TOK_COLON, TOK_OBJOPEN, 16'h001D, '0, 4'h0);
        send_token(TOK_OBJOPEN, TOK_OBJCLOSE, 16'h001E, '0, 4'h0);
        send_token(TOK_OBJCLOSE, TOK_OBJCLOSE, 16'h001F, '0, 4'h0);
        send_token(TOK_OBJCLOSE, TOK_END, 16'h0020, '0, 4'h0);
    endtask

    task automatic test_documents(input int send_pct, input int recv_pct, input int count);
        int goal;
        int depth;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = tokens_sent + count;
        while (tokens_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(3, 12)) send_rand(rand_kind(), rand_kind());
            end else begin
                if (pick <= 6)
                    depth = $urandom_range(1, 4);
                else if (pick <= 8)
                    depth = $urandom_range(5, 12);
                else
                    depth = $urandom_range(NEST_DEPTH, NEST_DEPTH + 2);
                send_document(depth, 2 * depth + $urandom_range(2, 30));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 28;
        recv_idle_pct = 58;
        test_token_kinds();
        test_key_naming();
        test_documents(28, 58, 550);
        test_documents(58, 28, 550);
        test_documents(0, 0, 550);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
